### hdl/rtwe_pkg.sv
// rtwe_pkg: shared types and constants for the route table with expiry
// no dependencies
`default_nettype none
package rtwe_pkg;
  localparam int NUM_ROUTES_DEF = 16;
  localparam int SLOT_W = 6;
  localparam int CNT_W = 7;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_LOCAL_ID = 1'b0;
  localparam logic REG_LIFETIME = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] dest;
    logic [31:0] nh;
    logic [7:0]  hops;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic              we;
    logic              replace;
    logic [SLOT_W-1:0] slot;
  } wr_t;

  typedef struct packed {
    logic              vld;
    logic              have;
    logic              matched;
    logic [SLOT_W-1:0] slot;
    logic              s_valid;
    logic              s_match;
    logic              s_hops_le;
    logic              s_expired;
    logic              s_live;
    logic              found;
    logic [31:0]       f_nh;
    logic [7:0]        f_hops;
    logic [31:0]       f_seen;
    logic [CNT_W-1:0]  cnt;
  } pkt_t;
endpackage
`default_nettype wire

### hdl/rtwe_if.sv
// rtwe_in_if and rtwe_out_if: valid/ready channels for requests and results
// no dependencies
`default_nettype none
interface rtwe_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] destination;
  logic [31:0] next_hop;
  logic [7:0]  hop_count;
  logic [31:0] now_ms;
  modport source (output valid, op, destination, next_hop, hop_count, now_ms, input ready);
  modport sink (input valid, op, destination, next_hop, hop_count, now_ms, output ready);
endinterface

interface rtwe_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] found_next_hop;
  logic [7:0]  found_hops;
  logic [31:0] found_last_seen;
  logic        replaced;
  logic        rejected;
  logic [6:0]  live_routes;
  modport source (output valid, found, found_next_hop, found_hops, found_last_seen,
                  replaced, rejected, live_routes, input ready);
  modport sink (input valid, found, found_next_hop, found_hops, found_last_seen,
                replaced, rejected, live_routes, output ready);
endinterface
`default_nettype wire

### hdl/rtwe_cell.sv
// rtwe_cell: one route entry plus the scan packet register passed to the next cell
// depends on rtwe_pkg
`default_nettype none
module rtwe_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rtwe_pkg::req_t req,
  input  wire logic [31:0]   life,
  input  wire rtwe_pkg::wr_t  wr,
  input  wire rtwe_pkg::pkt_t pkt_i,
  output rtwe_pkg::pkt_t     pkt_o
);
  import rtwe_pkg::*;

  logic        valid_r;
  logic [31:0] dest_r;
  logic [31:0] nh_r;
  logic [7:0]  hops_r;
  logic [31:0] seen_r;
  pkt_t        pkt_r;
  pkt_t        pkt_nxt;

  logic [31:0] age;
  logic        live;
  logic        dmatch;
  logic        take_match;
  logic        take_free;

  always_comb begin
    age        = req.now - seen_r;
    live       = valid_r && (age <= life);
    dmatch     = (dest_r == req.dest);
    take_match = !pkt_i.matched && valid_r && dmatch;
    take_free  = !pkt_i.matched && !valid_r && !pkt_i.have;
    pkt_nxt     = pkt_i;
    pkt_nxt.cnt = pkt_i.cnt + CNT_W'(live);
    if (req.op == OP_UPDATE) begin
      if (take_match) begin
        pkt_nxt.matched = 1'b1;
        pkt_nxt.have    = 1'b1;
      end else if (take_free) begin
        pkt_nxt.have = 1'b1;
      end
      if (IDX == 0 || take_match || take_free) begin
        pkt_nxt.slot      = SLOT_W'(IDX);
        pkt_nxt.s_valid   = valid_r;
        pkt_nxt.s_match   = dmatch;
        pkt_nxt.s_hops_le = req.hops <= hops_r;
        pkt_nxt.s_expired = age > life;
        pkt_nxt.s_live    = live;
      end
    end else begin
      if (!pkt_i.found && live && dmatch) begin
        pkt_nxt.found  = 1'b1;
        pkt_nxt.f_nh   = nh_r;
        pkt_nxt.f_hops = hops_r;
        pkt_nxt.f_seen = seen_r;
      end
    end
    if (!pkt_i.vld) begin
      pkt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pkt_r   <= '0;
    end else begin
      pkt_r <= pkt_nxt;
      if (wr.we && wr.slot == SLOT_W'(IDX) && wr.replace) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.slot == SLOT_W'(IDX)) begin
      seen_r <= req.now;
      if (wr.replace) begin
        dest_r <= req.dest;
        nh_r   <= req.nh;
        hops_r <= req.hops;
      end
    end
  end

  assign pkt_o = pkt_r;
endmodule
`default_nettype wire

### hdl/route_table_with_expiry_core.sv
// route_table_with_expiry_core: each accepted request is registered and scanned through the entry cells
// one transaction at a time: no new request is accepted until the previous result has been taken
// the scan packet walks the chain of entry cells, one cell a cycle, and its final state is registered as the result
// synchronous active-low reset invalidates all entries, resets the config registers and clears the handshake state
// depends on rtwe_pkg, rtwe_if and rtwe_cell
`default_nettype none
module route_table_with_expiry_core #(
  parameter int NUM_ROUTES = rtwe_pkg::NUM_ROUTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rtwe_in_if.sink          in_if,
  rtwe_out_if.source       out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import rtwe_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t      state_r;
  logic        start_r;
  req_t        req_r;
  logic [31:0] lid_r;
  logic [31:0] life_r;
  pkt_t        chain [NUM_ROUTES+1];
  pkt_t        last;
  wr_t         wr;
  logic        rej;
  logic [CNT_W-1:0] cnt_after;

  logic        out_valid_r;
  logic        found_r;
  logic [31:0] f_nh_r;
  logic [7:0]  f_hops_r;
  logic [31:0] f_seen_r;
  logic        repl_r;
  logic        rej_r;
  logic [CNT_W-1:0] live_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LIFETIME) ? life_r : lid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lid_r  <= 32'd0;
      life_r <= 32'd300000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_LIFETIME) begin
        life_r <= cfg_pwdata;
      end else begin
        lid_r <= cfg_pwdata;
      end
    end
  end

  assign chain[0] = pkt_t'{vld: start_r, default: '0};

  for (genvar k = 0; k < NUM_ROUTES; k++) begin : g_cell
    rtwe_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req_r),
      .life  (life_r),
      .wr    (wr),
      .pkt_i (chain[k]),
      .pkt_o (chain[k+1])
    );
  end

  assign last = chain[NUM_ROUTES];
  assign in_if.ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    rej = (req_r.op == OP_UPDATE) &&
          (req_r.dest == 32'd0 || req_r.dest == lid_r ||
           req_r.nh == 32'd0 || req_r.nh == lid_r);
    wr.we      = (state_r == S_SCAN) && last.vld && (req_r.op == OP_UPDATE) && !rej;
    wr.replace = !last.s_valid || !last.s_match || last.s_hops_le || last.s_expired;
    wr.slot    = last.slot;
    if (req_r.op == OP_UPDATE && !rej) begin
      cnt_after = last.cnt - CNT_W'(last.s_live) + CNT_W'(1);
    end else begin
      cnt_after = last.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            req_r.op   <= in_if.op;
            req_r.dest <= in_if.destination;
            req_r.nh   <= in_if.next_hop;
            req_r.hops <= in_if.hop_count;
            req_r.now  <= in_if.now_ms;
            start_r    <= 1'b1;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last.vld) begin
            out_valid_r <= 1'b1;
            found_r  <= last.found;
            f_nh_r   <= last.f_nh;
            f_hops_r <= last.f_hops;
            f_seen_r <= last.f_seen;
            repl_r   <= wr.we && wr.replace;
            rej_r    <= rej;
            live_r   <= cnt_after;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.found           = found_r;
  assign out_if.found_next_hop  = f_nh_r;
  assign out_if.found_hops      = f_hops_r;
  assign out_if.found_last_seen = f_seen_r;
  assign out_if.replaced        = repl_r;
  assign out_if.rejected        = rej_r;
  assign out_if.live_routes     = live_r;
endmodule
`default_nettype wire
